// ----- rtl/mtwf_pkg.sv -----
// Shared types and constants for the Modbus TCP write policy filter.
// Used by every module in rtl/; depends on nothing else.
`default_nettype none

package mtwf_pkg;

	// One byte of the request stream with its sender.
	typedef struct packed {
		logic [7:0]  frame_byte;
		logic [31:0] sender_ip;
	} in_item_t;

	// One verdict per frame.
	typedef struct packed {
		logic [2:0]  verdict;
		logic [1:0]  exc_code;
		logic [15:0] transaction_id;
		logic [7:0]  unit_id;
		logic [7:0]  function_code;
		logic [7:0]  response_function;
		logic [15:0] start_address;
		logic [15:0] item_count;
	} out_item_t;

	// Frame record handed from the parser to the policy stage.
	typedef struct packed {
		logic [15:0] transaction_id;
		logic [7:0]  unit_id;
		logic [7:0]  function_code;
		logic [15:0] start_address;
		logic [15:0] count_field;
		logic [31:0] sender_ip;
		logic        short_frame;
	} frame_rec_t;

	// Policy configuration.
	typedef struct packed {
		logic [31:0] trusted_ip;
		logic [15:0] reg_low;
		logic [15:0] reg_high;
		logic [15:0] coil_a_low;
		logic [15:0] coil_a_high;
		logic [15:0] coil_b_low;
		logic [15:0] coil_b_high;
	} cfg_t;

	// Register indexes of the configuration port.
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_TRUSTED_IP  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REG_LOW     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REG_HIGH    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_COIL_A_LOW  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_COIL_A_HIGH = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_COIL_B_LOW  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_COIL_B_HIGH = 3'd6;

	// Configuration values after reset.
	localparam logic [31:0] RST_TRUSTED_IP  = 32'h7F00_0002;
	localparam logic [15:0] RST_REG_LOW     = 16'd0;
	localparam logic [15:0] RST_REG_HIGH    = 16'd15;
	localparam logic [15:0] RST_COIL_A_LOW  = 16'd0;
	localparam logic [15:0] RST_COIL_A_HIGH = 16'd3;
	localparam logic [15:0] RST_COIL_B_LOW  = 16'd8;
	localparam logic [15:0] RST_COIL_B_HIGH = 16'd11;

	// Verdict codes.
	localparam logic [2:0] VERDICT_ALLOW     = 3'd0;
	localparam logic [2:0] VERDICT_UNTRUSTED = 3'd1;
	localparam logic [2:0] VERDICT_RANGE     = 3'd2;
	localparam logic [2:0] VERDICT_UNKNOWN   = 3'd3;
	localparam logic [2:0] VERDICT_SHORT     = 3'd4;

	// Exception codes.
	localparam logic [1:0] EXC_NONE         = 2'd0;
	localparam logic [1:0] EXC_ILLEGAL_FUNC = 2'd1;
	localparam logic [1:0] EXC_ILLEGAL_ADDR = 2'd2;

	// Function codes.
	localparam logic [7:0] FC_READ_COILS        = 8'd1;
	localparam logic [7:0] FC_READ_INPUT_REGS   = 8'd4;
	localparam logic [7:0] FC_WRITE_SINGLE_COIL = 8'd5;
	localparam logic [7:0] FC_WRITE_SINGLE_REG  = 8'd6;
	localparam logic [7:0] FC_WRITE_MULTI_COILS = 8'd15;
	localparam logic [7:0] FC_WRITE_MULTI_REGS  = 8'd16;
	localparam logic [7:0] EXC_FLAG             = 8'h80;

	// Byte positions within a frame.
	localparam int unsigned POS_W = 17;
	localparam logic [POS_W-1:0] POS_TRANS_HI  = 17'd0;
	localparam logic [POS_W-1:0] POS_TRANS_LO  = 17'd1;
	localparam logic [POS_W-1:0] POS_LEN_HI    = 17'd4;
	localparam logic [POS_W-1:0] POS_LEN_LO    = 17'd5;
	localparam logic [POS_W-1:0] POS_UNIT      = 17'd6;
	localparam logic [POS_W-1:0] POS_FUNC      = 17'd7;
	localparam logic [POS_W-1:0] POS_ADDR_HI   = 17'd8;
	localparam logic [POS_W-1:0] POS_ADDR_LO   = 17'd9;
	localparam logic [POS_W-1:0] POS_COUNT_HI  = 17'd10;
	localparam logic [POS_W-1:0] POS_COUNT_LO  = 17'd11;

	// Shortest body length that carries a function code.
	localparam logic [15:0] MIN_BODY_LEN = 16'd2;

endpackage

`default_nettype wire

// ----- rtl/mtwf_front.sv -----
// Front end: parses the MBAP header byte by byte and emits one frame record per frame.
// Depends on mtwf_pkg.
`default_nettype none

module mtwf_front
	import mtwf_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       frame_valid,
	input  wire in_item_t   frame_item,
	input  wire logic       q_full,
	output logic            push,
	output frame_rec_t      rec
);

	logic [POS_W-1:0] pos_q;
	logic [15:0]      blen_q;
	logic [15:0]      trans_q;
	logic [7:0]       unit_q;
	logic [7:0]       func_q;
	logic [15:0]      addr_q;
	logic [15:0]      count_q;

	logic [15:0]      blen_n;
	logic [15:0]      trans_n;
	logic [7:0]       unit_n;
	logic [7:0]       func_n;
	logic [15:0]      addr_n;
	logic [15:0]      count_n;
	logic [7:0]       b;
	logic             accept;
	logic             done;

	assign b      = frame_item.frame_byte;
	assign accept = frame_valid && !q_full;

	// Capture the header field that this byte belongs to.
	always_comb begin
		blen_n  = blen_q;
		trans_n = trans_q;
		unit_n  = unit_q;
		func_n  = func_q;
		addr_n  = addr_q;
		count_n = count_q;
		unique case (pos_q)
			POS_TRANS_HI: trans_n = {b, 8'h00};
			POS_TRANS_LO: trans_n = {trans_q[15:8], b};
			POS_LEN_HI:   blen_n  = {b, 8'h00};
			POS_LEN_LO:   blen_n  = {blen_q[15:8], b};
			POS_UNIT:     unit_n  = b;
			POS_FUNC:     func_n  = b;
			POS_ADDR_HI:  addr_n  = {b, 8'h00};
			POS_ADDR_LO:  addr_n  = {addr_q[15:8], b};
			POS_COUNT_HI: count_n = {b, 8'h00};
			POS_COUNT_LO: count_n = {count_q[15:8], b};
			default: begin
			end
		endcase
	end

	// The frame ends on the byte at position 5 plus the body length.
	assign done = (pos_q >= POS_LEN_LO) && (pos_q == (POS_LEN_LO + {1'b0, blen_n}));

	// Build the record from the values as they stand after this byte.
	always_comb begin
		rec.transaction_id = trans_n;
		rec.unit_id        = unit_n;
		rec.function_code  = func_n;
		rec.start_address  = addr_n;
		rec.count_field    = count_n;
		rec.sender_ip      = frame_item.sender_ip;
		rec.short_frame    = (blen_n < MIN_BODY_LEN);
	end

	assign push = accept && done;

	// Parser state; everything returns to zero after each frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			blen_q  <= '0;
			trans_q <= '0;
			unit_q  <= '0;
			func_q  <= '0;
			addr_q  <= '0;
			count_q <= '0;
		end else if (accept) begin
			if (done) begin
				pos_q   <= '0;
				blen_q  <= '0;
				trans_q <= '0;
				unit_q  <= '0;
				func_q  <= '0;
				addr_q  <= '0;
				count_q <= '0;
			end else begin
				pos_q   <= pos_q + 1'b1;
				blen_q  <= blen_n;
				trans_q <= trans_n;
				unit_q  <= unit_n;
				func_q  <= func_n;
				addr_q  <= addr_n;
				count_q <= count_n;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/mtwf_queue.sv -----
// Short queue of frame records between the parser and the policy stage.
// Depends on mtwf_pkg.
`default_nettype none

module mtwf_queue
	import mtwf_pkg::*;
#(
	parameter int unsigned DEPTH = 2
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       push,
	input  wire frame_rec_t                 push_rec,
	input  wire logic                       pop,
	output frame_rec_t                      head_rec,
	output logic                            head_valid,
	output logic                            full,
	output logic [$clog2(DEPTH+1)-1:0]      count
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	frame_rec_t    entry_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
		next_ptr = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign head_rec   = entry_q[rd_ptr_q];
	assign head_valid = (count_q != '0);
	assign full       = (count_q == CW'(DEPTH));
	assign count      = count_q;

	// Record storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_rec;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/mtwf_back.sv -----
// Back end: applies the write policy to a frame record and holds the verdict.
// Depends on mtwf_pkg.
`default_nettype none

module mtwf_back
	import mtwf_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cfg_t       cfg,
	input  wire logic       head_valid,
	input  wire frame_rec_t head_rec,
	output logic            pop,
	output logic            verdict_valid,
	input  wire logic       verdict_stall,
	output out_item_t       verdict_item
);

	logic        valid_q;
	out_item_t   item_q;
	out_item_t   item_n;

	logic [7:0]  fc;
	logic [15:0] addr;
	logic [15:0] qty;
	logic [15:0] span;
	logic [15:0] last;
	logic        single_write;
	logic        coil_write;
	logic        fits_a;
	logic        fits_b;
	logic        fits_reg;
	logic        range_ok;
	logic [2:0]  verdict;
	logic [1:0]  exc;

	assign fc           = head_rec.function_code;
	assign addr         = head_rec.start_address;
	assign single_write = (fc == FC_WRITE_SINGLE_COIL) || (fc == FC_WRITE_SINGLE_REG);
	assign coil_write   = (fc == FC_WRITE_SINGLE_COIL) || (fc == FC_WRITE_MULTI_COILS);
	assign qty          = single_write ? 16'd1 : head_rec.count_field;

	// Last address of the range, wrapping at 64K; a zero quantity covers one item.
	assign span = (qty == 16'd0) ? 16'd0 : qty - 16'd1;
	assign last = addr + span;

	// Window checks; a reversed window can hold only a range that wraps at 64K.
	assign fits_a   = (addr >= cfg.coil_a_low) && (last <= cfg.coil_a_high);
	assign fits_b   = (addr >= cfg.coil_b_low) && (last <= cfg.coil_b_high);
	assign fits_reg = (addr >= cfg.reg_low) && (last <= cfg.reg_high);
	assign range_ok = coil_write ? (fits_a || fits_b) : fits_reg;

	// Verdict, in order of precedence.
	always_comb begin
		priority if (head_rec.short_frame) begin
			verdict = VERDICT_SHORT;
		end else if ((fc >= FC_READ_COILS) && (fc <= FC_READ_INPUT_REGS)) begin
			verdict = VERDICT_ALLOW;
		end else if (!single_write && (fc != FC_WRITE_MULTI_COILS)
				&& (fc != FC_WRITE_MULTI_REGS)) begin
			verdict = VERDICT_UNKNOWN;
		end else if (head_rec.sender_ip != cfg.trusted_ip) begin
			verdict = VERDICT_UNTRUSTED;
		end else begin
			verdict = range_ok ? VERDICT_ALLOW : VERDICT_RANGE;
		end
	end

	// Exception code and reply function code follow from the verdict.
	always_comb begin
		if (verdict == VERDICT_RANGE) begin
			exc = EXC_ILLEGAL_ADDR;
		end else if ((verdict == VERDICT_UNTRUSTED) || (verdict == VERDICT_UNKNOWN)) begin
			exc = EXC_ILLEGAL_FUNC;
		end else begin
			exc = EXC_NONE;
		end
		item_n.verdict           = verdict;
		item_n.exc_code          = exc;
		item_n.transaction_id    = head_rec.transaction_id;
		item_n.unit_id           = head_rec.unit_id;
		item_n.function_code     = fc;
		item_n.response_function = (exc != EXC_NONE) ? (fc | EXC_FLAG) : 8'h00;
		item_n.start_address     = addr;
		item_n.item_count        = qty;
	end

	// Take the next record when the output register is free or being emptied.
	assign pop = head_valid && (!valid_q || !verdict_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || !verdict_stall) begin
			valid_q <= head_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= item_n;
		end
	end

	assign verdict_valid = valid_q;
	assign verdict_item  = item_q;

endmodule

`default_nettype wire

// ----- rtl/modbus_tcp_write_policy_filter.sv -----
// Top level of the Modbus TCP write policy filter: configuration registers,
// parser, record queue and policy stage. Depends on mtwf_pkg and the mtwf_* modules.
//
// Channel   Direction  Handshake                  Transaction
// frame     in         frame_valid / frame_stall  one request byte and its sender IPv4
// verdict   out        verdict_valid / verdict_stall  one verdict at the end of a frame
// cfg       in         cfg_we                     one register write, no read-back
//
// One request byte is taken every cycle while frame_stall is low. The edge that takes
// a frame's last byte writes its record into the queue; the output register takes the
// verdict when free or being emptied. Reset clears the parser, queue and output and
// loads the default policy. A stalled verdict holds in the output register while up to
// QUEUE_DEPTH records wait behind it; frame_stall rises only when that queue is full.
`default_nettype none

module modbus_tcp_write_policy_filter
	import mtwf_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 frame_valid,
	output logic                      frame_stall,
	input  wire in_item_t             frame_item,
	output logic                      verdict_valid,
	input  wire logic                 verdict_stall,
	output out_item_t                 verdict_item,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]          cfg_data
);

	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

	cfg_t          cfg_q;
	frame_rec_t    push_rec;
	frame_rec_t    head_rec;
	logic          push;
	logic          pop;
	logic          head_valid;
	logic          q_full;
	logic [CW-1:0] q_count;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.trusted_ip  <= RST_TRUSTED_IP;
			cfg_q.reg_low     <= RST_REG_LOW;
			cfg_q.reg_high    <= RST_REG_HIGH;
			cfg_q.coil_a_low  <= RST_COIL_A_LOW;
			cfg_q.coil_a_high <= RST_COIL_A_HIGH;
			cfg_q.coil_b_low  <= RST_COIL_B_LOW;
			cfg_q.coil_b_high <= RST_COIL_B_HIGH;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TRUSTED_IP:  cfg_q.trusted_ip  <= cfg_data;
				CFG_REG_LOW:     cfg_q.reg_low     <= cfg_data[15:0];
				CFG_REG_HIGH:    cfg_q.reg_high    <= cfg_data[15:0];
				CFG_COIL_A_LOW:  cfg_q.coil_a_low  <= cfg_data[15:0];
				CFG_COIL_A_HIGH: cfg_q.coil_a_high <= cfg_data[15:0];
				CFG_COIL_B_LOW:  cfg_q.coil_b_low  <= cfg_data[15:0];
				CFG_COIL_B_HIGH: cfg_q.coil_b_high <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	// Header parser.
	mtwf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.frame_valid(frame_valid),
		.frame_item (frame_item),
		.q_full     (q_full),
		.push       (push),
		.rec        (push_rec)
	);

	// Frame record queue.
	mtwf_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_rec  (push_rec),
		.pop       (pop),
		.head_rec  (head_rec),
		.head_valid(head_valid),
		.full      (q_full),
		.count     (q_count)
	);

	// Policy stage and output register.
	mtwf_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.head_valid   (head_valid),
		.head_rec     (head_rec),
		.pop          (pop),
		.verdict_valid(verdict_valid),
		.verdict_stall(verdict_stall),
		.verdict_item (verdict_item)
	);

	assign frame_stall = q_full;

	// A record pushed without a pop grows the queue by exactly one.
	a_queue_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (q_count == $past(q_count) + 1'b1))
		else $error("queue count did not grow on push");

	// A record popped without a push shrinks the queue by exactly one.
	a_queue_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> (q_count == $past(q_count) - 1'b1))
		else $error("queue count did not shrink on pop");

	// Allowed and ignored frames carry no exception; denied ones flag the reply code.
	a_exception_match: assert property (@(posedge clk) disable iff (!arst_n)
		verdict_valid |->
		(((verdict_item.verdict == VERDICT_ALLOW) || (verdict_item.verdict == VERDICT_SHORT))
			? ((verdict_item.exc_code == EXC_NONE)
				&& (verdict_item.response_function == 8'h00))
			: ((verdict_item.exc_code != EXC_NONE)
				&& verdict_item.response_function[7])))
		else $error("exception code does not match verdict");

endmodule

`default_nettype wire
